/* rtl/pf_pkg.sv */
// Shared types and constants for the Playfair digraph encryptor.
package pf_pkg;

  localparam int LW    = 5;          // letter code width
  localparam int SIDE  = 5;          // key square side
  localparam int CW    = 3;          // row / column index width
  localparam int RW    = SIDE * LW;  // key row width
  localparam int IDX_W = 3;          // configuration index width

  localparam logic [LW-1:0] CODE_X = 5'd23;
  localparam logic [LW-1:0] CODE_I = 5'd8;
  localparam logic [LW-1:0] CODE_J = 5'd9;

  localparam logic [IDX_W-1:0] REG_KEY_ROW0 = 3'd0;
  localparam logic [IDX_W-1:0] REG_KEY_ROW1 = 3'd1;
  localparam logic [IDX_W-1:0] REG_KEY_ROW2 = 3'd2;
  localparam logic [IDX_W-1:0] REG_KEY_ROW3 = 3'd3;
  localparam logic [IDX_W-1:0] REG_KEY_ROW4 = 3'd4;

  localparam int JOB_DEPTH_DEF = 4;
  localparam int OUT_DEPTH_DEF = 4;

  typedef logic [LW-1:0] letter_t;
  typedef logic [CW-1:0] coord_t;
  typedef logic [SIDE-1:0][RW-1:0] key_t;

  // One queued job: pair (a, b); when two is set a second pair (a, X) follows.
  typedef struct packed {
    letter_t a;
    letter_t b;
    logic    two;
  } job_t;

  typedef struct packed {
    letter_t ch;
    logic    last;
    logic    miss;
  } res_t;

  function automatic coord_t inc_wrap(input coord_t x);
    return (x == coord_t'(SIDE - 1)) ? coord_t'(0) : coord_t'(x + coord_t'(1));
  endfunction

endpackage

/* rtl/pf_fifo.sv */
// Small synchronous queue used between pipeline parts.
module pf_fifo import pf_pkg::*; #(
  parameter int WIDTH = 1,
  parameter int DEPTH = JOB_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [NW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == NW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : PW'(wp_r + PW'(1));
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : PW'(rp_r + PW'(1));
    end
    if (do_push && !do_pop) begin
      cnt_nxt = NW'(cnt_r + NW'(1));
    end else if (do_pop && !do_push) begin
      cnt_nxt = NW'(cnt_r - NW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

/* rtl/pf_front.sv */
// Front end: folds J to I, pairs letters and queues digraph jobs.
module pf_front import pf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_push,
  input  letter_t in_letter,
  input  logic    in_message_end,
  input  logic    q_full,
  output logic    q_push,
  output job_t    q_job
);

  logic    pend_vld_r, pend_vld_nxt;
  letter_t pend_r, pend_nxt;
  letter_t lf;
  logic    accept;

  assign lf     = (in_letter == CODE_J) ? CODE_I : in_letter;
  assign accept = in_push && !q_full;

  always_comb begin
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    q_push       = 1'b0;
    q_job        = '{a: lf, b: CODE_X, two: 1'b0};
    if (accept) begin
      if (pend_vld_r && (pend_r == lf)) begin
        // doubled letter: pad with X, second copy starts the next pair
        q_push       = 1'b1;
        q_job.two    = in_message_end;
        pend_vld_nxt = !in_message_end;
        pend_nxt     = in_message_end ? '0 : lf;
      end else if (pend_vld_r) begin
        q_push       = 1'b1;
        q_job.a      = pend_r;
        q_job.b      = lf;
        pend_vld_nxt = 1'b0;
        pend_nxt     = '0;
      end else if (in_message_end) begin
        // lone final letter: pad with X
        q_push = 1'b1;
      end else begin
        pend_vld_nxt = 1'b1;
        pend_nxt     = lf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
      pend_r     <= '0;
    end else begin
      pend_vld_r <= pend_vld_nxt;
      pend_r     <= pend_nxt;
    end
  end

endmodule

/* rtl/pf_back.sv */
// Back end: locates each pair in the key square and emits two cipher letters.
module pf_back import pf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  key_t key,
  input  logic jq_empty,
  input  job_t jq_job,
  output logic jq_pop,
  input  logic oq_full,
  output logic oq_push,
  output res_t oq_res
);

  // pair stage
  logic    sel_r, sel_nxt;
  logic    p_vld_r, p_vld_nxt;
  letter_t p_a_r, p_b_r;
  logic    p_last_r;
  // substitution stage
  logic    l_vld_r, l_vld_nxt, l_half_r, l_half_nxt;
  coord_t  l_ra_r, l_ca_r, l_rb_r, l_cb_r;
  logic    l_miss_r, l_last_r;

  logic    p_take, l_take, l_done, p_load;
  logic    fa, fb;
  coord_t  ra, ca, rb, cb, na_r, na_c, nb_r, nb_c;
  coord_t  o_r, o_c;

  assign oq_push = l_vld_r && !oq_full;
  assign l_done  = oq_push && l_half_r;
  assign l_take  = !l_vld_r || l_done;
  assign p_take  = !p_vld_r || l_take;
  assign p_load  = !jq_empty && p_take;
  assign jq_pop  = p_load && (sel_r || !jq_job.two);

  // search the square; the last match in row-major order wins
  always_comb begin
    fa = 1'b0;
    fb = 1'b0;
    ra = '0;
    ca = '0;
    rb = '0;
    cb = '0;
    for (int r = 0; r < SIDE; r++) begin
      for (int c = 0; c < SIDE; c++) begin
        if (key[r][c*LW +: LW] == p_a_r) begin
          fa = 1'b1;
          ra = coord_t'(r);
          ca = coord_t'(c);
        end
        if (key[r][c*LW +: LW] == p_b_r) begin
          fb = 1'b1;
          rb = coord_t'(r);
          cb = coord_t'(c);
        end
      end
    end
  end

  always_comb begin
    na_r = ra;
    na_c = ca;
    nb_r = rb;
    nb_c = cb;
    if (ra == rb) begin
      na_c = inc_wrap(ca);
      nb_c = inc_wrap(cb);
    end else if (ca == cb) begin
      na_r = inc_wrap(ra);
      nb_r = inc_wrap(rb);
    end else begin
      na_c = cb;
      nb_c = ca;
    end
  end

  always_comb begin
    sel_nxt = sel_r;
    p_vld_nxt = p_vld_r;
    if (p_take) begin
      p_vld_nxt = p_load;
      if (p_load) begin
        sel_nxt = jq_job.two && !sel_r;
      end
    end
    l_vld_nxt  = l_vld_r;
    l_half_nxt = l_half_r;
    if (oq_push) begin
      l_half_nxt = !l_half_r;
    end
    if (l_take) begin
      l_vld_nxt  = p_vld_r;
      l_half_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r    <= 1'b0;
      p_vld_r  <= 1'b0;
      l_vld_r  <= 1'b0;
      l_half_r <= 1'b0;
    end else begin
      sel_r    <= sel_nxt;
      p_vld_r  <= p_vld_nxt;
      l_vld_r  <= l_vld_nxt;
      l_half_r <= l_half_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (p_load) begin
      p_a_r    <= jq_job.a;
      p_b_r    <= sel_r ? CODE_X : jq_job.b;
      p_last_r <= sel_r || !jq_job.two;
    end
    if (l_take && p_vld_r) begin
      l_ra_r   <= na_r;
      l_ca_r   <= na_c;
      l_rb_r   <= nb_r;
      l_cb_r   <= nb_c;
      l_miss_r <= !(fa && fb);
      l_last_r <= p_last_r;
    end
  end

  assign o_r = l_half_r ? l_rb_r : l_ra_r;
  assign o_c = l_half_r ? l_cb_r : l_ca_r;

  always_comb begin
    oq_res.ch   = l_miss_r ? letter_t'(0) : key[o_r][o_c*LW +: LW];
    oq_res.last = l_half_r && l_last_r;
    oq_res.miss = l_miss_r;
  end

endmodule

/* rtl/playfair_digraph_encrypt.sv */
// Top level of the Playfair digraph encryptor.
//
//   channel | ports                                        | transfer when
//   --------+----------------------------------------------+--------------------
//   input   | in_push, in_full, in_letter, in_message_end  | in_push & !in_full
//   result  | out_pop, out_empty, out_cipher_letter,       | out_pop & !out_empty
//           | out_run_last, out_not_in_square              |
//   config  | cfg_we, cfg_index, cfg_wdata                 | cfg_we
//
// The substitution stage emits the two cipher letters of each pair one after
// the other, so an item yields zero, two or four result letters. A result
// passes through the job queue, the pair stage, the substitution stage and
// the output queue.
// Reset clears the key rows, the held letter and both queues.
// Input stalls only when the job queue is full; result stalls back up
// through the output queue into the substitution stage.
module playfair_digraph_encrypt import pf_pkg::*; #(
  parameter int JOB_DEPTH = JOB_DEPTH_DEF,
  parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  // input channel
  input  logic             in_push,
  output logic             in_full,
  input  logic [LW-1:0]    in_letter,
  input  logic             in_message_end,
  // result channel
  output logic             out_empty,
  input  logic             out_pop,
  output logic [LW-1:0]    out_cipher_letter,
  output logic             out_run_last,
  output logic             out_not_in_square,
  // configuration
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [RW-1:0]    cfg_wdata
);

  key_t key_r;
  logic jq_push, jq_full, jq_pop, jq_empty;
  job_t jq_wjob, jq_rjob;
  logic oq_push, oq_full;
  res_t oq_wres, oq_rres;

  // Key square rows; writes to indexes past the last row are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_ROW0: key_r[0] <= cfg_wdata;
        REG_KEY_ROW1: key_r[1] <= cfg_wdata;
        REG_KEY_ROW2: key_r[2] <= cfg_wdata;
        REG_KEY_ROW3: key_r[3] <= cfg_wdata;
        REG_KEY_ROW4: key_r[4] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Front: pair up letters, queue one job per completed item.
  pf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_letter      (in_letter),
    .in_message_end (in_message_end),
    .q_full         (jq_full),
    .q_push         (jq_push),
    .q_job          (jq_wjob)
  );

  assign in_full = jq_full;

  // Job queue decouples pairing from substitution.
  pf_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (JOB_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (jq_push),
    .wdata (jq_wjob),
    .full  (jq_full),
    .pop   (jq_pop),
    .rdata (jq_rjob),
    .empty (jq_empty)
  );

  // Back: locate and substitute, one cipher letter per cycle while the output queue is not full.
  pf_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .key      (key_r),
    .jq_empty (jq_empty),
    .jq_job   (jq_rjob),
    .jq_pop   (jq_pop),
    .oq_full  (oq_full),
    .oq_push  (oq_push),
    .oq_res   (oq_wres)
  );

  // Output queue holds finished results until popped.
  pf_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .wdata (oq_wres),
    .full  (oq_full),
    .pop   (out_pop),
    .rdata (oq_rres),
    .empty (out_empty)
  );

  assign out_cipher_letter = oq_rres.ch;
  assign out_run_last      = oq_rres.last;
  assign out_not_in_square = oq_rres.miss;

endmodule

/* rtl/pf_checker.sv */
// Port-level checks for the Playfair digraph encryptor, bound to the top level.
module pf_checker import pf_pkg::*; (
  input logic          clk,
  input logic          rst_n,
  input logic          out_empty,
  input logic          out_pop,
  input logic [LW-1:0] out_cipher_letter,
  input logic          out_run_last,
  input logic          out_not_in_square
);

  // reset drains every queued result
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("results visible right after reset");

  // a flagged pair carries letter code zero
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_not_in_square |-> out_cipher_letter == '0)
    else $error("missing-letter result with nonzero code");

  // a waiting result holds until it is taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_cipher_letter)
      && $stable(out_run_last) && $stable(out_not_in_square))
    else $error("waiting result changed or vanished");

endmodule

bind playfair_digraph_encrypt pf_checker u_pf_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_empty         (out_empty),
  .out_pop           (out_pop),
  .out_cipher_letter (out_cipher_letter),
  .out_run_last      (out_run_last),
  .out_not_in_square (out_not_in_square)
);
